// File: hdl/ps2mt_pkg.sv
// shared constants and types for the ps2 mouse packet cursor tracker
`default_nettype none

package ps2mt_pkg;

  // default cursor coordinate width
  localparam int COORD_BITS_DEF = 12;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int SIZE_W      = 13;
  localparam int WHEEL_W     = 16;
  localparam int MOVE_W      = 10;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

  // status byte bit positions
  localparam int ST_LEFT    = 0;
  localparam int ST_RIGHT   = 1;
  localparam int ST_MIDDLE  = 2;
  localparam int ST_X_SIGN  = 4;
  localparam int ST_Y_SIGN  = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENABLE        = 2'd0,
    CFG_WHEEL_MODE    = 2'd1,
    CFG_SCREEN_WIDTH  = 2'd2,
    CFG_SCREEN_HEIGHT = 2'd3
  } cfg_index_t;

  // which packet byte comes next
  typedef enum logic [1:0] {
    BYTE_STATUS = 2'd0,
    BYTE_X      = 2'd1,
    BYTE_Y      = 2'd2,
    BYTE_WHEEL  = 2'd3
  } byte_pos_t;

endpackage

`default_nettype wire

// File: hdl/ps2mt_axis_clamp.sv
// one cursor axis: add a signed move to the position and clamp to the screen
`default_nettype none

module ps2mt_axis_clamp #(
  parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
  input  wire logic [COORD_BITS-1:0]              pos,
  input  wire logic signed [ps2mt_pkg::MOVE_W-1:0] move,
  input  wire logic [ps2mt_pkg::SIZE_W-1:0]        size,
  output logic      [COORD_BITS-1:0]              pos_new
);

  localparam int VW    = COORD_BITS + 2;
  localparam int LIM_W = (COORD_BITS + 1 > ps2mt_pkg::SIZE_W) ?
                         COORD_BITS + 1 : ps2mt_pkg::SIZE_W;

  logic signed [VW-1:0] sum;
  logic [LIM_W-1:0]     size_ext;
  logic [LIM_W-1:0]     cap;
  logic [LIM_W-1:0]     lim;
  logic [LIM_W-1:0]     sum_mag;
  logic [LIM_W-1:0]     lim_m1;

  always_comb begin
    sum      = $signed({2'b00, pos}) + VW'(move);
    size_ext = LIM_W'(size);
    cap      = LIM_W'(1) << COORD_BITS;
    lim      = (size_ext > cap) ? cap : size_ext;
    if (lim == '0) begin
      lim = LIM_W'(1);
    end
    lim_m1  = lim - LIM_W'(1);
    sum_mag = LIM_W'(sum[VW-2:0]);
    if (sum[VW-1]) begin
      pos_new = '0;
    end else if (sum_mag >= lim) begin
      pos_new = lim_m1[COORD_BITS-1:0];
    end else begin
      pos_new = sum_mag[COORD_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hdl/ps2_mouse_packet_cursor_tracker.sv
// top level: ps2 mouse byte stream to cursor position, buttons and wheel total
`default_nettype none

// channel   dir  handshake               payload
// in_       in   in_tvalid/in_tready     tdata: data_byte; tuser: aux_flag
// out_      out  out_tvalid/out_tready   tdata: cursor_x, cursor_y, wheel_total
//                                        tuser: left, right, middle button
// cfg_      in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// one byte per cycle unless a stalled result holds it back; a byte waits in the input
// register and its packet result is written to the output register as the byte leaves it
// a stalled result holds the pipeline only when the next byte is ready to be
// processed; rst_n (sync, active low) clears control, positions and wheel total
// configuration is always ready and takes effect on the next edge

module ps2_mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tuser,   // [0] aux_flag

  output logic out_tvalid,
  input  wire logic out_tready,
  // [COORD_BITS-1:0] cursor_x, then cursor_y, then 16-bit wheel_total, zero pad
  output logic [((2*COORD_BITS+ps2mt_pkg::WHEEL_W+7)/8)*8-1:0] out_tdata,
  output logic [2:0] out_tuser,       // [0] left, [1] right, [2] middle button

  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ps2mt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ps2mt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int WW    = ps2mt_pkg::WHEEL_W;
  localparam int MW    = ps2mt_pkg::MOVE_W;

  // configuration registers
  logic                          enable_r;
  logic                          wheel_mode_r;
  logic [ps2mt_pkg::SIZE_W-1:0]  width_r;
  logic [ps2mt_pkg::SIZE_W-1:0]  height_r;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_aux_r;

  // packet assembly and tracking state
  ps2mt_pkg::byte_pos_t pos_r, pos_nxt;
  logic [7:0]           status_r;
  logic [7:0]           x_byte_r;
  logic [7:0]           y_byte_r;
  logic [COORD_BITS-1:0] pos_x_r;
  logic [COORD_BITS-1:0] pos_y_r;
  logic [WW-1:0]         wheel_r;

  // output register
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;
  logic [WW-1:0]         out_wheel_r;
  logic [2:0]            out_btn_r;

  logic advance;
  logic take;
  logic finish;
  logic add_wheel;
  logic [7:0]            dy_byte;
  logic signed [MW-1:0]  move_x;
  logic signed [MW-1:0]  move_y;
  logic [COORD_BITS-1:0] pos_x_nxt;
  logic [COORD_BITS-1:0] pos_y_nxt;
  logic [WW-1:0]         wheel_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      wheel_mode_r <= 1'b0;
      width_r      <= ps2mt_pkg::WIDTH_RESET;
      height_r     <= ps2mt_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (ps2mt_pkg::cfg_index_t'(cfg_index))
        ps2mt_pkg::CFG_ENABLE:        enable_r     <= cfg_data[0];
        ps2mt_pkg::CFG_WHEEL_MODE:    wheel_mode_r <= cfg_data[0];
        ps2mt_pkg::CFG_SCREEN_WIDTH:  width_r      <= cfg_data;
        ps2mt_pkg::CFG_SCREEN_HEIGHT: height_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // the held byte moves on when the output slot is free or being emptied
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || !out_valid_r || out_tready;
  // dropped bytes still advance but touch nothing
  assign take      = advance && enable_r && in_aux_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
      in_aux_r  <= in_tuser;
    end
  end

  // next byte position
  always_comb begin
    pos_nxt = pos_r;
    if (take) begin
      case (pos_r)
        ps2mt_pkg::BYTE_STATUS: pos_nxt = ps2mt_pkg::BYTE_X;
        ps2mt_pkg::BYTE_X:      pos_nxt = ps2mt_pkg::BYTE_Y;
        ps2mt_pkg::BYTE_Y:      pos_nxt = wheel_mode_r ? ps2mt_pkg::BYTE_WHEEL :
                                                         ps2mt_pkg::BYTE_STATUS;
        ps2mt_pkg::BYTE_WHEEL:  pos_nxt = ps2mt_pkg::BYTE_STATUS;
        default:                pos_nxt = ps2mt_pkg::BYTE_STATUS;
      endcase
    end
  end

  // packet completion and wheel add, mode sampled as the byte is processed
  always_comb begin
    finish    = 1'b0;
    add_wheel = 1'b0;
    case (pos_r)
      ps2mt_pkg::BYTE_Y:     finish = take && !wheel_mode_r;
      ps2mt_pkg::BYTE_WHEEL: begin
        finish    = take;
        add_wheel = wheel_mode_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= ps2mt_pkg::BYTE_STATUS;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // packet bytes, no reset: status and x are always written before use
  always_ff @(posedge clk) begin
    if (take && pos_r == ps2mt_pkg::BYTE_STATUS) status_r <= in_byte_r;
    if (take && pos_r == ps2mt_pkg::BYTE_X)      x_byte_r <= in_byte_r;
    if (take && pos_r == ps2mt_pkg::BYTE_Y)      y_byte_r <= in_byte_r;
  end

  // y movement byte is the live one on a three-byte finish, stored otherwise
  assign dy_byte = (pos_r == ps2mt_pkg::BYTE_Y) ? in_byte_r : y_byte_r;

  // 9-bit movements, sign from the status byte; y is negated (down positive)
  assign move_x = $signed({status_r[ps2mt_pkg::ST_X_SIGN], status_r[ps2mt_pkg::ST_X_SIGN],
                           x_byte_r});
  assign move_y = -$signed({status_r[ps2mt_pkg::ST_Y_SIGN],
                            status_r[ps2mt_pkg::ST_Y_SIGN], dy_byte});

  ps2mt_axis_clamp #(
    .COORD_BITS(COORD_BITS)
  ) u_clamp_x (
    .pos     (pos_x_r),
    .move    (move_x),
    .size    (width_r),
    .pos_new (pos_x_nxt)
  );

  ps2mt_axis_clamp #(
    .COORD_BITS(COORD_BITS)
  ) u_clamp_y (
    .pos     (pos_y_r),
    .move    (move_y),
    .size    (height_r),
    .pos_new (pos_y_nxt)
  );

  // wrapping wheel total, byte sign extended
  assign wheel_nxt = add_wheel ? wheel_r + {{(WW-8){in_byte_r[7]}}, in_byte_r} : wheel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      wheel_r <= '0;
    end else if (finish) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      wheel_r <= wheel_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_x_r     <= pos_x_nxt;
      out_y_r     <= pos_y_nxt;
      out_wheel_r <= wheel_nxt;
      out_btn_r   <= {status_r[ps2mt_pkg::ST_MIDDLE], status_r[ps2mt_pkg::ST_RIGHT],
                      status_r[ps2mt_pkg::ST_LEFT]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_btn_r;

  always_comb begin
    out_tdata = '0;
    out_tdata[COORD_BITS-1:0]                 = out_x_r;
    out_tdata[2*COORD_BITS-1:COORD_BITS]      = out_y_r;
    out_tdata[2*COORD_BITS+WW-1:2*COORD_BITS] = out_wheel_r;
  end

endmodule

`default_nettype wire

// File: bench/tb_ps2_mouse_packet_cursor_tracker.sv
// testbench for the ps2 mouse packet cursor tracker, checked against a cursor predictor
module tb_ps2_mouse_packet_cursor_tracker;

  localparam int CB            = ps2mt_pkg::COORD_BITS_DEF;
  localparam int WW            = ps2mt_pkg::WHEEL_W;
  localparam int SW            = ps2mt_pkg::SIZE_W;
  localparam int CDW           = ps2mt_pkg::CFG_DATA_W;
  localparam int CIW           = ps2mt_pkg::CFG_INDEX_W;
  localparam int OUT_W         = ((2*CB + WW + 7)/8)*8;
  // this leaves plenty of margin over the slowest run
  localparam int LIMIT_CYCLES  = 400000;
  // a byte that completes no packet may still sit in the input register
  localparam int SETTLE_CYCLES = 8;
  localparam int END_WAIT      = 2000;
  localparam int LONG_HOLD     = 150;
  localparam int MAX_PRINT     = 20;

  // one cursor report as it leaves the block
  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [WW-1:0] wheel;
    logic          left;
    logic          right;
    logic          middle;
  } cursor_report_t;

  // cursor predictor plus the queue of reports still owed by the block
  class cursor_scoreboard;
    bit                   enable;
    bit                   wheel_mode;
    logic [SW-1:0]        scr_w;
    logic [SW-1:0]        scr_h;
    ps2mt_pkg::byte_pos_t next_pos;
    logic [7:0]           status_b;
    logic [7:0]           x_b;
    logic [7:0]           y_b;
    logic [CB-1:0]        cur_x;
    logic [CB-1:0]        cur_y;
    logic [WW-1:0]        wheel_acc;
    cursor_report_t       expected_reports[$];
    int                   errors;
    int                   packets_seen;
    int                   bytes_taken;
    int                   bytes_dropped;
    int                   cfg_writes;

    function new();
      enable        = 1'b0;
      wheel_mode    = 1'b0;
      scr_w         = ps2mt_pkg::WIDTH_RESET;
      scr_h         = ps2mt_pkg::HEIGHT_RESET;
      next_pos      = ps2mt_pkg::BYTE_STATUS;
      status_b      = '0;
      x_b           = '0;
      y_b           = '0;
      cur_x         = '0;
      cur_y         = '0;
      wheel_acc     = '0;
      errors        = 0;
      packets_seen  = 0;
      bytes_taken   = 0;
      bytes_dropped = 0;
      cfg_writes    = 0;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void write_reg(ps2mt_pkg::cfg_index_t idx, logic [CDW-1:0] val);
      cfg_writes++;
      case (idx)
        ps2mt_pkg::CFG_ENABLE:        enable = val[0];
        ps2mt_pkg::CFG_WHEEL_MODE:    wheel_mode = val[0];
        ps2mt_pkg::CFG_SCREEN_WIDTH:  scr_w = val;
        ps2mt_pkg::CFG_SCREEN_HEIGHT: scr_h = val;
        default: ;
      endcase
    endfunction

    // screen limit is capped at the coordinate range, a zero size acts as one
    function logic [CB-1:0] clamp_axis(int v, logic [SW-1:0] size);
      int lim;
      lim = int'(size);
      if (lim > (1 << CB)) lim = 1 << CB;
      if (lim == 0) lim = 1;
      if (v < 0) return '0;
      if (v >= lim) return CB'(lim - 1);
      return CB'(v);
    endfunction

    function void close_packet(bit with_wheel, logic [7:0] wb);
      int             dx;
      int             dy;
      cursor_report_t r;
      dx = $signed({status_b[ps2mt_pkg::ST_X_SIGN], x_b});
      dy = $signed({status_b[ps2mt_pkg::ST_Y_SIGN], y_b});
      if (with_wheel) wheel_acc = wheel_acc + {{(WW-8){wb[7]}}, wb};
      cur_x = clamp_axis(int'(cur_x) + dx, scr_w);
      // y movement is up positive, the row counts downward
      cur_y = clamp_axis(int'(cur_y) - dy, scr_h);
      r.x      = cur_x;
      r.y      = cur_y;
      r.wheel  = wheel_acc;
      r.left   = status_b[ps2mt_pkg::ST_LEFT];
      r.right  = status_b[ps2mt_pkg::ST_RIGHT];
      r.middle = status_b[ps2mt_pkg::ST_MIDDLE];
      expected_reports.push_back(r);
    endfunction

    function void note_byte(logic [7:0] d, logic aux);
      if (!enable || !aux) begin
        bytes_dropped++;
        return;
      end
      bytes_taken++;
      case (next_pos)
        ps2mt_pkg::BYTE_STATUS: begin
          status_b = d;
          next_pos = ps2mt_pkg::BYTE_X;
        end
        ps2mt_pkg::BYTE_X: begin
          x_b      = d;
          next_pos = ps2mt_pkg::BYTE_Y;
        end
        ps2mt_pkg::BYTE_Y: begin
          y_b = d;
          // wheel mode is sampled per byte, so a mid-packet change counts here
          if (wheel_mode) begin
            next_pos = ps2mt_pkg::BYTE_WHEEL;
          end else begin
            next_pos = ps2mt_pkg::BYTE_STATUS;
            close_packet(1'b0, 8'h00);
          end
        end
        default: begin
          // a fourth byte always closes, the wheel only counts if still enabled
          next_pos = ps2mt_pkg::BYTE_STATUS;
          close_packet(wheel_mode, d);
        end
      endcase
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= MAX_PRINT)
        $display("mismatch after %0d packets: %s got 0x%0h expected 0x%0h",
                 packets_seen, what, got, want);
    endtask

    task check_result(logic [OUT_W-1:0] data, logic [2:0] flags);
      cursor_report_t want;
      if (expected_reports.size() == 0) begin
        report_mismatch("report with nothing outstanding", data, 0);
        return;
      end
      want = expected_reports.pop_front();
      packets_seen++;
      if (data[CB-1:0] !== want.x) report_mismatch("cursor_x", data[CB-1:0], want.x);
      if (data[2*CB-1:CB] !== want.y) report_mismatch("cursor_y", data[2*CB-1:CB], want.y);
      if (data[2*CB+WW-1:2*CB] !== want.wheel)
        report_mismatch("wheel_total", data[2*CB+WW-1:2*CB], want.wheel);
      if (flags[0] !== want.left) report_mismatch("left_button", flags[0], want.left);
      if (flags[1] !== want.right) report_mismatch("right_button", flags[1], want.right);
      if (flags[2] !== want.middle) report_mismatch("middle_button", flags[2], want.middle);
    endtask
  endclass

  // every dut input starts at a known value
  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;  // [7:0] data_byte
  logic             in_tuser   = 1'b0; // [0] aux_flag
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;        // cursor_x, cursor_y, wheel_total from bit 0 up
  logic [2:0]       out_tuser;        // [0] left, [1] right, [2] middle
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [CIW-1:0]   cfg_index  = ps2mt_pkg::CFG_ENABLE;
  logic [CDW-1:0]   cfg_data   = '0;

  cursor_scoreboard sb;
  logic             hold_req   = 1'b0; // asks the result sink for one long hold-off
  bit               tx_no_gaps = 1'b0; // sender offers back to back while set
  int               cycles     = 0;

  ps2_mouse_packet_cursor_tracker #(
    .COORD_BITS(CB)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // every accepted result transaction is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
      sb.check_result(out_tdata, out_tuser);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result sink: random stalls, ready stretches, and one long hold-off on request
  initial begin : result_sink
    int stall;
    int run;
    int k;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_req   <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) begin
          @(posedge clk);
          if (hold_req) break;
        end
      end
      if (!hold_req) begin
        k   = $urandom_range(0, 99);
        run = (k < 70) ? $urandom_range(1, 4) :
              (k < 90) ? $urandom_range(5, 20) : $urandom_range(30, 80);
        out_tready <= 1'b1;
        repeat (run) begin
          @(posedge clk);
          if (hold_req) break;
        end
      end
    end
  end

  // offer one byte, note it once the transaction completes, then maybe back off
  task automatic send_byte(logic [7:0] d, logic aux);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= aux;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_byte(d, aux);
    gap = tx_no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and let the block run dry before touching registers
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(ps2mt_pkg::cfg_index_t idx, logic [CDW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, val);
  endtask

  // writes all four registers; flag registers get random upper bits
  task automatic configure(bit en, bit wm, logic [CDW-1:0] w, logic [CDW-1:0] h);
    logic [CDW-1:0] flag_word;
    settle();
    flag_word    = CDW'($urandom);
    flag_word[0] = en;
    write_reg(ps2mt_pkg::CFG_ENABLE, flag_word);
    flag_word    = CDW'($urandom);
    flag_word[0] = wm;
    write_reg(ps2mt_pkg::CFG_WHEEL_MODE, flag_word);
    write_reg(ps2mt_pkg::CFG_SCREEN_WIDTH, w);
    write_reg(ps2mt_pkg::CFG_SCREEN_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // mostly whole packets with random content, plus ignored bytes and stray bytes
  // pull_pct above 50 drifts the cursor toward the bottom-right corner
  task automatic random_phase(int n_items, int pull_pct, bit with_hold);
    int         counted;
    int         burst_left;
    int         len;
    int         k;
    bit         hold_done;
    logic [7:0] pkt [4];
    counted    = 0;
    burst_left = 0;
    hold_done  = 1'b0;
    while (counted < n_items) begin
      if (with_hold && !hold_done && counted >= n_items/3) begin
        // long receiver hold while the sender keeps pushing: block must back up
        hold_req   <= 1'b1;
        hold_done  = 1'b1;
        burst_left = 15;
      end else if (burst_left == 0 && $urandom_range(0, 99) < 4) begin
        burst_left = $urandom_range(3, 10);
      end
      tx_no_gaps = (burst_left > 0);
      if (burst_left > 0) burst_left--;
      k = $urandom_range(0, 99);
      if (k < 7) begin
        // controller byte, not from the mouse
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (k < 13) begin
        // stray mouse byte knocks the packet framing off
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        counted++;
      end else begin
        len    = sb.wheel_mode ? 4 : 3;
        pkt[0] = 8'($urandom_range(0, 255));
        pkt[0][ps2mt_pkg::ST_X_SIGN] = ($urandom_range(0, 99) >= pull_pct);
        pkt[0][ps2mt_pkg::ST_Y_SIGN] = ($urandom_range(0, 99) < pull_pct);
        pkt[1] = 8'($urandom_range(0, 255));
        pkt[2] = 8'($urandom_range(0, 255));
        pkt[3] = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 4) send_byte(8'($urandom_range(0, 255)), 1'b0);
          send_byte(pkt[i], 1'b1);
        end
        counted += len;
      end
    end
    tx_no_gaps = 1'b0;
  endtask

  initial begin : stimulus
    int w;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // still disabled after reset: mouse bytes are dropped
    send_byte(8'h08, 1'b1);
    send_byte(8'hFF, 1'b1);

    configure(1'b1, 1'b0, 13'd640, 13'd480);
    // full positive x move, left button, a controller byte in the middle
    send_byte(8'h09, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    // most negative x and y: x pins at 0, cursor moves down 256
    send_byte(8'h3E, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    // overflow bits set, all buttons, x +128, y up 127
    send_byte(8'hC7, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b1);

    // wheel mode dropped after the y byte: fourth byte closes without wheel
    configure(1'b1, 1'b1, 13'd640, 13'd480);
    send_byte(8'h08, 1'b1);
    send_byte(8'h10, 1'b1);
    send_byte(8'hF0, 1'b1);
    configure(1'b1, 1'b0, 13'd640, 13'd480);
    send_byte(8'h7F, 1'b1);

    // wheel mode raised before the y byte: packet waits for a wheel byte
    send_byte(8'h28, 1'b1);
    send_byte(8'h05, 1'b1);
    configure(1'b1, 1'b1, 13'd640, 13'd480);
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b1);

    // disabled in mid-packet: the byte is lost, framing resumes where it was
    configure(1'b1, 1'b0, 13'd640, 13'd480);
    send_byte(8'h01, 1'b1);
    configure(1'b0, 1'b0, 13'd640, 13'd480);
    send_byte(8'h55, 1'b1);
    configure(1'b1, 1'b0, 13'd640, 13'd480);
    send_byte(8'h02, 1'b1);
    send_byte(8'h03, 1'b1);

    // random phases over screen sizes and wheel modes, extremes included
    configure(1'b1, 1'b1, 13'd4096, 13'd4096);
    random_phase(90, 80, 1'b0);
    // shrink: far positions clamp on the next packet
    configure(1'b1, 1'b0, 13'd100, 13'd60);
    random_phase(80, 50, 1'b1);
    // zero width pins x, oversized height caps at the coordinate range
    configure(1'b1, 1'b1, 13'd0, 13'd8191);
    random_phase(70, 65, 1'b0);
    configure(1'b1, 1'b0, 13'd8191, 13'd1);
    random_phase(70, 70, 1'b0);
    configure(1'b1, 1'($urandom_range(0, 1)), CDW'($urandom_range(1, 4096)),
              CDW'($urandom_range(1, 4096)));
    random_phase(80, 50, 1'b0);
    configure(1'b1, 1'b1, 13'd640, 13'd480);
    random_phase(80, 50, 1'b1);

    in_tvalid <= 1'b0;
    for (w = 0; w < END_WAIT && sb.pending() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("reports never delivered", sb.pending(), 0);

    $display("covered %0d mouse bytes taken, %0d dropped, %0d cursor reports checked",
             sb.bytes_taken, sb.bytes_dropped, sb.packets_seen);
    $display("%0d register writes: framing, mode changes, clamping and wheel totals",
             sb.cfg_writes);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
